>>> design/linear_probe_hash_table_macros.svh
// Assertion macros for the linear probe hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht: check failed");
`define LPHT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht: check failed");
`else
`define LPHT_ASSERT_IMP(label, ante, cons)
`define LPHT_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> design/lpht_pkg.sv
// Types, constants and helpers shared by the linear probe hash table.
package lpht_pkg;

  localparam int SLOTS   = 1024;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SLOT_FW = 10;
  localparam int CNT_FW  = 11;
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 32;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OPC_INSERT = 2'd0,
    OPC_SEARCH = 2'd1,
    OPC_REMOVE = 2'd2,
    OPC_SPARE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MK_FREE = 2'd0,
    MK_USED = 2'd1,
    MK_GONE = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_SEARCH,
    KIND_REMOVE
  } kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } back_state_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_FW-1:0]  slot;
    logic [CNT_FW-1:0]   stored_count;
  } out_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [SLOT_W-1:0]       home;
  } cmd_t;

  typedef struct packed {
    mark_t            mark;
    logic [KEY_W-1:0] key;
  } slot_ent_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] pos);
    logic [SLOT_W-1:0] nxt;
    if (pos == SLOT_W'(SLOTS - 1)) begin
      nxt = '0;
    end else begin
      nxt = pos + 1'b1;
    end
    return nxt;
  endfunction

endpackage

>>> design/lpht_front.sv
// Front end: accepts input beats, decodes the op, computes the home slot and queues commands.
module lpht_front import lpht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  cmd_t              dec;

  assign in_stall  = (cnt_r == QCNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    dec.key   = in_item.key;
    dec.value = in_item.value;
    dec.home  = SLOT_W'(in_item.key % SLOTS);
    unique case (opcode_t'(in_item.op))
      OPC_INSERT: dec.kind = KIND_INSERT;
      OPC_REMOVE: dec.kind = KIND_REMOVE;
      OPC_SEARCH: dec.kind = KIND_SEARCH;
      default:    dec.kind = KIND_SEARCH;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> design/lpht_back.sv
// Back end: slot memories, clearing pass, probe sequencer and result register.
module lpht_back import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  slot_ent_t         slot_mem_r [SLOTS];
  logic [VAL_W-1:0]  value_mem_r [SLOTS];
  slot_ent_t         rd_ent_r;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              out_free;
  logic [SLOT_W-1:0] pos_adv;
  logic              key_hit;
  logic              wrap;
  logic              finish;
  status_t           res_status;
  logic              ent_we;
  slot_ent_t         ent_wdata;
  logic [SLOT_W-1:0] wr_addr;
  logic              val_we;
  logic [SLOT_W-1:0] rd_addr;

  assign out_free = !out_valid_r || !out_stall;
  assign cmd_pop  = (state_r == BK_IDLE) && cmd_valid && out_free;
  assign pos_adv  = next_slot(pos_r);
  assign key_hit  = (rd_ent_r.key == cmd_r.key);
  assign wrap     = (pos_adv == cmd_r.home);

  // probe decision
  always_comb begin
    finish     = 1'b0;
    res_status = ST_OK;
    ent_we     = 1'b0;
    ent_wdata  = '{mark: MK_FREE, key: '0};
    wr_addr    = pos_r;
    val_we     = 1'b0;
    count_nxt  = count_r;
    unique case (state_r)
      BK_CLEAR: begin
        ent_we  = 1'b1;
        wr_addr = clr_r;
      end
      BK_IDLE: begin
      end
      BK_PROBE: begin
        if (cmd_r.kind == KIND_INSERT) begin
          if (rd_ent_r.mark != MK_USED || key_hit) begin
            finish    = 1'b1;
            ent_we    = 1'b1;
            val_we    = 1'b1;
            ent_wdata = '{mark: MK_USED, key: cmd_r.key};
            if (rd_ent_r.mark != MK_USED) begin
              count_nxt = count_r + 1'b1;
            end
          end else if (wrap) begin
            finish     = 1'b1;
            res_status = ST_FULL;
          end
        end else begin
          if (rd_ent_r.mark == MK_FREE) begin
            finish     = 1'b1;
            res_status = ST_MISS;
          end else if (rd_ent_r.mark == MK_USED && key_hit) begin
            finish = 1'b1;
            if (cmd_r.kind == KIND_REMOVE) begin
              ent_we    = 1'b1;
              ent_wdata = '{mark: MK_GONE, key: rd_ent_r.key};
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
            end
          end else if (wrap) begin
            finish     = 1'b1;
            res_status = ST_MISS;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: if (clr_r == SLOT_W'(SLOTS - 1)) state_nxt = BK_IDLE;
      BK_IDLE:  if (cmd_pop) state_nxt = BK_PROBE;
      BK_PROBE: if (finish) state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  // datapath and result
  always_comb begin
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    clr_nxt       = clr_r;
    rd_addr       = pos_adv;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      BK_CLEAR: clr_nxt = clr_r + 1'b1;
      BK_IDLE: begin
        rd_addr = cmd.home;
        if (cmd_pop) begin
          cmd_nxt = cmd;
          pos_nxt = cmd.home;
        end
      end
      BK_PROBE: begin
        pos_nxt = pos_adv;
        if (finish) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = res_status;
          out_item_nxt.slot         = (res_status == ST_OK) ? SLOT_FW'(pos_r) : '0;
          out_item_nxt.stored_count = CNT_FW'(count_nxt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      slot_mem_r[wr_addr] <= ent_wdata;
    end
    rd_ent_r <= slot_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem_r[wr_addr] <= cmd_r.value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/linear_probe_hash_table.sv
// Top level of the linear probe hash table: front end, command queue and probe engine.
//
//   channel  dir  handshake           beat
//   in_      in   in_valid/in_stall   in_item  (op, key, value)
//   out_     out  out_valid/out_stall out_item (status, slot, stored_count)
//
// In the probe engine an op probes p slots, p being 1 to SLOTS, starting at its home slot,
// one slot-memory read per cycle; the read port sets the rate.
// After reset a clearing pass over all SLOTS (1024) slots marks every slot free; no beat
// is taken once the two-entry command queue fills during it.
// The input side keeps accepting into the queue while a result waits under out_stall.
`include "linear_probe_hash_table_macros.svh"
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  lpht_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lpht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `LPHT_ASSERT_IMP(a_pop_needs_cmd, cmd_pop, cmd_valid)
  `LPHT_ASSERT_IMP(a_count_bound, out_valid, out_item.stored_count <= CNT_FW'(SLOTS))
  `LPHT_ASSERT_IMP(a_slot_zero_on_err, out_valid && out_item.status != ST_OK, out_item.slot == '0)
  `LPHT_ASSERT_IMP(a_no_pop_under_stall, out_valid && out_stall, !cmd_pop)
  `LPHT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

endmodule
